/* rtl/lrupr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the LRU page replacement block.
// Used by lrupr_cell and lru_page_replacement; depends on nothing.

package lrupr_pkg;

	// Fixed field widths of the item ports.
	localparam int unsigned CFG_W      = 4;
	localparam int unsigned PAGE_IN_W  = 16;
	localparam int unsigned SLOT_OUT_W = 3;
	localparam int unsigned TOTAL_W    = 32;

	localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 4'd3;

	// Lookup flags handed from one cell to the next.
	typedef struct packed {
		logic hit;
		logic vic;
	} lrupr_link_t;

	// Update command broadcast to every cell.
	typedef struct packed {
		logic en;
		logic hit;
	} lrupr_apply_t;

endpackage

/* rtl/lrupr_cell.sv */
`timescale 1ns / 1ps
// One page frame of the replacement chain: page, occupied flag and recency rank.
// Depends on lrupr_pkg.

module lrupr_cell
	import lrupr_pkg::*;
#(
	parameter int unsigned IDX    = 0,
	parameter int unsigned SLOT_W = 3,
	parameter int unsigned RANK_W = 3,
	parameter int unsigned PAGE_W = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	// lookup
	input  logic [PAGE_W-1:0] look_page,
	input  logic [RANK_W-1:0] last_rank,
	input  lrupr_link_t       link_in,
	input  logic [SLOT_W-1:0] hit_slot_in,
	input  logic [RANK_W-1:0] hit_rank_in,
	input  logic [SLOT_W-1:0] vic_slot_in,
	input  logic [PAGE_W-1:0] vic_page_in,
	output lrupr_link_t       link_out,
	output logic [SLOT_W-1:0] hit_slot_out,
	output logic [RANK_W-1:0] hit_rank_out,
	output logic [SLOT_W-1:0] vic_slot_out,
	output logic [PAGE_W-1:0] vic_page_out,
	// update
	input  lrupr_apply_t      apply,
	input  logic [SLOT_W-1:0] apply_slot,
	input  logic [RANK_W-1:0] apply_rank,
	input  logic [PAGE_W-1:0] apply_page
);

	localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

	logic [PAGE_W-1:0] page_q;
	logic              occ_q;
	logic [RANK_W-1:0] rank_q;
	logic              match;
	logic              victim;
	logic              sel;

	// Occupied ranks always form a permutation of 0 to count-1, so the oldest
	// page is the one whose rank equals count-1.
	assign match  = occ_q && (page_q == look_page);
	assign victim = occ_q && (rank_q == last_rank);
	assign sel    = (apply_slot == MY_SLOT);

	always_comb begin
		link_out.hit = link_in.hit | match;
		link_out.vic = link_in.vic | victim;
		hit_slot_out = (match && !link_in.hit) ? MY_SLOT : hit_slot_in;
		hit_rank_out = (match && !link_in.hit) ? rank_q : hit_rank_in;
		vic_slot_out = (victim && !link_in.vic) ? MY_SLOT : vic_slot_in;
		vic_page_out = (victim && !link_in.vic) ? page_q : vic_page_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= 1'b0;
			rank_q <= '0;
		end else if (apply.en) begin
			if (sel) begin
				occ_q  <= 1'b1;
				rank_q <= '0;
			end else if (occ_q && (!apply.hit || rank_q < apply_rank)) begin
				rank_q <= rank_q + RANK_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (apply.en && sel && !apply.hit) begin
			page_q <= apply_page;
		end
	end

endmodule

/* rtl/lru_page_replacement.sv */
`timescale 1ns / 1ps
// Top level of the LRU page replacement block: configuration, control and result register.
// Depends on lrupr_pkg and lrupr_cell.

// When an item is accepted, the lookup ripples through the chain of frame
// cells (page compare, hit rank, oldest page) and the decision is registered;
// in the cycle after, every cell ages or loads itself and the result register
// is filled. The ripple through FRAMES cells is the long path. A new item is
// accepted at the same edge that takes the result, as long as the output side
// does not stall; the block takes no new item while it applies the last one.
// frames_in_use values of 0 act as 1, values above FRAMES act as FRAMES;
// lowering it keeps the resident pages.

module lru_page_replacement
	import lrupr_pkg::*;
#(
	parameter int unsigned FRAMES    = 8,
	parameter int unsigned PAGE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_wr_en,
	input  logic [CFG_W-1:0]      cfg_wr_data,
	// input items
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PAGE_IN_W-1:0]  page_number,
	// result items
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  hit,
	output logic [SLOT_OUT_W-1:0] frame_slot,
	output logic                  evicted_valid,
	output logic [PAGE_IN_W-1:0]  evicted_page,
	output logic [TOTAL_W-1:0]    hit_total,
	output logic [TOTAL_W-1:0]    miss_total
);

	localparam int unsigned SW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int unsigned RW = SW;
	localparam int unsigned CW = $clog2(FRAMES + 1);
	localparam int unsigned LW = (CW > CFG_W) ? CW : CFG_W;

	logic [CFG_W-1:0]     frames_q;
	logic [CW-1:0]        count_q;
	logic [TOTAL_W-1:0]   hit_cnt_q;
	logic [TOTAL_W-1:0]   miss_cnt_q;
	logic                 busy_q;

	logic                 hit_s1;
	logic                 fill_s1;
	logic                 evict_s1;
	logic [SW-1:0]        slot_s1;
	logic [RW-1:0]        rank_s1;
	logic [PAGE_BITS-1:0] page_s1;
	logic [PAGE_BITS-1:0] evpage_s1;

	logic                 out_valid_q;
	logic                 hit_q;
	logic [SLOT_OUT_W-1:0] slot_q;
	logic                 evv_q;
	logic [PAGE_IN_W-1:0] evp_q;

	logic [PAGE_BITS-1:0] look_page;
	logic [RW-1:0]        last_rank;
	logic [LW-1:0]        cfg_ext;
	logic [LW-1:0]        lim;
	logic                 in_acc;
	logic                 look_hit;
	logic                 look_fill;
	logic                 look_evict;
	logic [SW-1:0]        look_slot;
	lrupr_apply_t         apply;

	lrupr_link_t          link     [FRAMES+1];
	logic [SW-1:0]        hit_slot [FRAMES+1];
	logic [RW-1:0]        hit_rank [FRAMES+1];
	logic [SW-1:0]        vic_slot [FRAMES+1];
	logic [PAGE_BITS-1:0] vic_page [FRAMES+1];

	assign look_page = PAGE_BITS'(page_number);
	assign last_rank = RW'(count_q - CW'(1));
	assign in_stall  = busy_q || (out_valid_q && out_stall);
	assign in_acc    = in_valid && !in_stall;

	assign link[0]     = '0;
	assign hit_slot[0] = '0;
	assign hit_rank[0] = '0;
	assign vic_slot[0] = '0;
	assign vic_page[0] = '0;

	assign apply.en  = busy_q;
	assign apply.hit = hit_s1;

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		lrupr_cell #(
			.IDX    (i),
			.SLOT_W (SW),
			.RANK_W (RW),
			.PAGE_W (PAGE_BITS)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.look_page    (look_page),
			.last_rank    (last_rank),
			.link_in      (link[i]),
			.hit_slot_in  (hit_slot[i]),
			.hit_rank_in  (hit_rank[i]),
			.vic_slot_in  (vic_slot[i]),
			.vic_page_in  (vic_page[i]),
			.link_out     (link[i+1]),
			.hit_slot_out (hit_slot[i+1]),
			.hit_rank_out (hit_rank[i+1]),
			.vic_slot_out (vic_slot[i+1]),
			.vic_page_out (vic_page[i+1]),
			.apply        (apply),
			.apply_slot   (slot_s1),
			.apply_rank   (rank_s1),
			.apply_page   (page_s1)
		);
	end

	always_comb begin
		cfg_ext = LW'(frames_q);
		if (cfg_ext == '0) begin
			lim = LW'(1);
		end else if (cfg_ext > LW'(FRAMES)) begin
			lim = LW'(FRAMES);
		end else begin
			lim = cfg_ext;
		end
	end

	// Frames are filled from the bottom and never freed, so the next free
	// frame is the one indexed by the occupied count.
	always_comb begin
		look_hit   = link[FRAMES].hit;
		look_fill  = !look_hit && (LW'(count_q) < lim);
		look_evict = !look_hit && !look_fill && link[FRAMES].vic;
		priority if (look_hit) begin
			look_slot = hit_slot[FRAMES];
		end else if (look_fill) begin
			look_slot = SW'(count_q);
		end else begin
			look_slot = vic_slot[FRAMES];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_IN_USE_RESET;
		end else if (cfg_wr_en) begin
			frames_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			hit_s1    <= look_hit;
			fill_s1   <= look_fill;
			evict_s1  <= look_evict;
			slot_s1   <= look_slot;
			rank_s1   <= hit_rank[FRAMES];
			page_s1   <= look_page;
			evpage_s1 <= vic_page[FRAMES];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			busy_q <= in_acc;
			if (busy_q) begin
				out_valid_q <= 1'b1;
				if (fill_s1) begin
					count_q <= count_q + CW'(1);
				end
				if (hit_s1) begin
					if (hit_cnt_q != '1) begin
						hit_cnt_q <= hit_cnt_q + TOTAL_W'(1);
					end
				end else if (miss_cnt_q != '1) begin
					miss_cnt_q <= miss_cnt_q + TOTAL_W'(1);
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			hit_q  <= hit_s1;
			slot_q <= SLOT_OUT_W'(slot_s1);
			evv_q  <= evict_s1;
			evp_q  <= evict_s1 ? PAGE_IN_W'(evpage_s1) : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign frame_slot    = slot_q;
	assign evicted_valid = evv_q;
	assign evicted_page  = evp_q;
	assign hit_total     = hit_cnt_q;
	assign miss_total    = miss_cnt_q;

endmodule

/* rtl/lrupr_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for lru_page_replacement, attached by the bind below.
// Depends only on the top level's ports.

module lrupr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        hit,
	input logic [2:0]  frame_slot,
	input logic        evicted_valid,
	input logic [15:0] evicted_page,
	input logic [31:0] hit_total,
	input logic [31:0] miss_total
);

	// A hit never replaces a page.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> !evicted_valid)
		else $error("hit item reports an eviction");

	a_evpage_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evicted_valid |-> evicted_page == 16'd0)
		else $error("evicted page not zero without eviction");

	// The totals only grow or hold.
	a_totals_grow: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (hit_total >= $past(hit_total)) && (miss_total >= $past(miss_total)))
		else $error("hit or miss total went down");

	// An accepted item keeps the lookup busy for the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after an accept");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(frame_slot) && $stable(hit_total))
		else $error("stalled result changed");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (.*);
